// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the sliding window median block.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define SWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication, disabled while reset is asserted
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |-> cons) else $error(msg);

`endif

// ===== rtl/core/swm_pkg.sv =====
// Package for the sliding window median and cost block.
// Widths, cell record and control struct; used by all modules.
package swm_pkg;

  localparam int WIN_MAX  = 64;
  localparam int SAMPLE_W = 32;
  localparam int COST_W   = 38;
  localparam int IDX_W    = $clog2(WIN_MAX);
  localparam int CNT_W    = IDX_W + 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] val;
    logic [IDX_W-1:0]    age;
    logic                valid;
  } cell_t;

  typedef struct packed {
    logic clear;
    logic rem;
    logic ins;
    logic load;
    logic shift;
  } ctl_t;

endpackage

// ===== rtl/core/swm_cell.sv =====
// One cell of the sorted window chain: value, age tag, valid, readout tap.
// Depends on swm_pkg.
module swm_cell import swm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_t                ctl,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [IDX_W-1:0]    k_last,
  input  cell_t               left,
  input  logic                g_left,
  input  cell_t               right,
  input  logic                del_in,
  input  logic [SAMPLE_W-1:0] rd_right,
  output cell_t               cur,
  output logic                g,
  output logic                del_out,
  output logic [SAMPLE_W-1:0] rd
);

  cell_t               cell_r;
  logic [SAMPLE_W-1:0] rd_r;
  logic                rm_self;
  logic                sh_down;

  assign rm_self = ctl.rem & cell_r.valid & (cell_r.age == k_last);
  assign del_out = del_in | rm_self;
  assign sh_down = ctl.rem & del_out;
  assign g       = !cell_r.valid | (cell_r.val > sample);
  assign cur     = cell_r;
  assign rd      = rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (ctl.clear) begin
      cell_r.valid <= 1'b0;
    end else if (sh_down) begin
      cell_r.valid <= right.valid;
    end else if (ctl.ins && g) begin
      cell_r.valid <= g_left ? left.valid : 1'b1;
    end
    if (sh_down) begin
      cell_r.val <= right.val;
      cell_r.age <= right.age;
    end else if (ctl.ins) begin
      if (g && g_left) begin
        cell_r.val <= left.val;
        cell_r.age <= left.age + 1'b1;
      end else if (g) begin
        cell_r.val <= sample;
        cell_r.age <= '0;
      end else begin
        cell_r.age <= cell_r.age + 1'b1;
      end
    end
    if (ctl.load) begin
      rd_r <= cell_r.val;
    end else if (ctl.shift) begin
      rd_r <= rd_right;
    end
  end

endmodule

// ===== rtl/core/sliding_window_median_cost.sv =====
// Sliding window median and absolute deviation cost, sorted chain of cells.
// Depends on swm_pkg, swm_cell and assert_macros.svh.
//
// Usage: write window_size (1..64, 0 taken as 1, larger saturated) on
// cfg_we/cfg_window_size while idle; this empties the window. Samples come
// on in_valid/in_sample and are taken when in_stall is low. The first
// window_size-1 samples after reset or a write give no result; each later
// sample gives one out_median/out_cost item.
// With k = window_size, m = (k-1)/2: the item is taken in the idle state, the
// oldest sample is removed (full window only), the item is inserted, the
// readout chain is loaded and shifted to the median at index m, the cost of
// all k cells is accumulated and the result is registered. The next item is
// taken only once the result is registered, as the one shared accumulator
// walks the cell chain. A sample with no result is inserted and the block
// goes back to idle.
// Reset empties the window and sets window_size to 1. A finished result
// waits in the output register while out_stall is high; the next sample is
// accepted meanwhile and its result waits, with in_stall high, until the
// register is free.
module sliding_window_median_cost import swm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_window_size,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_median,
  output logic [COST_W-1:0]   out_cost
);
`include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REM  = 3'd1;
  localparam logic [2:0] ST_INS  = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_MED  = 3'd4;
  localparam logic [2:0] ST_SUM  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    win_r, fill_r, cnt_r;
  logic [SAMPLE_W-1:0] sample_r, med_r, diff_r;
  logic [COST_W-1:0]   acc_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_median_r;
  logic [COST_W-1:0]   out_cost_r;
  logic [CNT_W-1:0]    cfg_sat;
  logic [IDX_W-1:0]    k_last, med_idx;
  ctl_t                ctl;

  cell_t               cells   [WIN_MAX];
  logic                gs      [WIN_MAX];
  logic                dels    [WIN_MAX];
  logic [SAMPLE_W-1:0] rds     [WIN_MAX];

  assign k_last  = IDX_W'(win_r - 1'b1);
  assign med_idx = k_last >> 1;
  assign cfg_sat = (cfg_window_size == '0) ? CNT_W'(1) :
                   (cfg_window_size > CNT_W'(WIN_MAX)) ? CNT_W'(WIN_MAX) : cfg_window_size;

  always_comb begin
    ctl       = '0;
    ctl.clear = cfg_we;
    ctl.rem   = (state_r == ST_REM);
    ctl.ins   = (state_r == ST_INS);
    ctl.load  = (state_r == ST_LOAD) ||
                (state_r == ST_MED && cnt_r == CNT_W'(med_idx));
    ctl.shift = (state_r == ST_MED) || (state_r == ST_SUM);
  end

  for (genvar i = 0; i < WIN_MAX; i++) begin : g_cell
    cell_t               lc, rc;
    logic                gl, di;
    logic [SAMPLE_W-1:0] rr;
    if (i == 0) begin : g_first
      assign lc = '0;
      assign gl = 1'b0;
      assign di = 1'b0;
    end else begin : g_mid
      assign lc = cells[i-1];
      assign gl = gs[i-1];
      assign di = dels[i-1];
    end
    if (i == WIN_MAX-1) begin : g_last
      assign rc = '0;
      assign rr = '0;
    end else begin : g_inner
      assign rc = cells[i+1];
      assign rr = rds[i+1];
    end
    swm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .sample   (sample_r),
      .k_last   (k_last),
      .left     (lc),
      .g_left   (gl),
      .right    (rc),
      .del_in   (di),
      .rd_right (rr),
      .cur      (cells[i]),
      .g        (gs[i]),
      .del_out  (dels[i]),
      .rd       (rds[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = (fill_r == win_r) ? ST_REM : ST_INS;
      ST_REM:  state_nxt = ST_INS;
      ST_INS:  state_nxt = (fill_r != win_r && fill_r + 1'b1 != win_r) ? ST_IDLE : ST_LOAD;
      ST_LOAD: state_nxt = ST_MED;
      ST_MED:  if (cnt_r == CNT_W'(med_idx)) state_nxt = ST_SUM;
      ST_SUM:  if (cnt_r == win_r - 1'b1) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= CNT_W'(1);
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        win_r  <= cfg_sat;
        fill_r <= '0;
      end else if (state_r == ST_INS && fill_r != win_r) begin
        fill_r <= fill_r + 1'b1;
      end
      if (state_r == ST_LOAD || (state_r == ST_MED && cnt_r == CNT_W'(med_idx))) begin
        cnt_r <= '0;
      end else if (state_r == ST_MED || state_r == ST_SUM) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      sample_r <= in_sample;
    end
    if (state_r == ST_MED && cnt_r == CNT_W'(med_idx)) begin
      med_r  <= rds[0];
      diff_r <= '0;
      acc_r  <= '0;
    end else if (state_r == ST_SUM) begin
      diff_r <= (rds[0] >= med_r) ? rds[0] - med_r : med_r - rds[0];
      acc_r  <= acc_r + COST_W'(diff_r);
    end else if (state_r == ST_FIN) begin
      acc_r  <= acc_r + COST_W'(diff_r);
    end
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      out_median_r <= med_r;
      out_cost_r   <= acc_r;
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;
  assign out_cost   = out_cost_r;

  `SWM_ASSERT(a_fill_le_win, fill_r <= win_r, "fill count exceeds window size")
  `SWM_ASSERT(a_win_range, win_r >= CNT_W'(1) && win_r <= CNT_W'(WIN_MAX), "bad window size")
  `SWM_ASSERT_IMP(a_out_from_fsm, $rose(out_valid_r), $past(state_r == ST_OUT), "result without finish")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for sliding_window_median_cost: median and absolute
// deviation cost of a sliding sample window. Depends on swm_pkg and the RTL.
module tb_top import swm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [SAMPLE_W-1:0] median;
    logic [COST_W-1:0]   cost;
  } window_res_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CNT_W-1:0]    cfg_window_size = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_median;
  logic [COST_W-1:0]   out_cost;

  window_res_t         expected_results[$];
  logic [SAMPLE_W-1:0] arrivals[WIN_MAX];
  logic [SAMPLE_W-1:0] sorted_vals[$];
  int                  win_len = 1;
  int                  held = 0;
  int                  oldest = 0;
  int                  errors = 0;
  int                  in_idle_pct = 32;
  int                  out_idle_pct = 32;
  int                  hold_off = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sliding_window_median_cost dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_window_size(cfg_window_size),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_median(out_median),
    .out_cost(out_cost)
  );

  task automatic sorted_put(input logic [SAMPLE_W-1:0] v);
    int i;
    i = 0;
    while (i < sorted_vals.size() && sorted_vals[i] <= v) i++;
    sorted_vals.insert(i, v);
  endtask

  task automatic predict_window(input logic [SAMPLE_W-1:0] s);
    window_res_t r;
    logic [SAMPLE_W-1:0] med;
    logic [COST_W-1:0] acc;
    acc = '0;
    if (held < win_len) begin
      arrivals[held] = s;
      sorted_put(s);
      held++;
      oldest = 0;
      if (held < win_len) return;
    end else begin
      foreach (sorted_vals[i])
        if (sorted_vals[i] == arrivals[oldest]) begin
          sorted_vals.delete(i);
          break;
        end
      sorted_put(s);
      arrivals[oldest] = s;
      oldest = (oldest + 1) % win_len;
    end
    med = sorted_vals[(win_len - 1) / 2];
    foreach (sorted_vals[i])
      acc += (sorted_vals[i] >= med) ? COST_W'(sorted_vals[i] - med)
                                     : COST_W'(med - sorted_vals[i]);
    r.median = med;
    r.cost = acc;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    predict_window(s);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
  endtask

  task automatic set_window(input int k);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_window_size <= CNT_W'(k);
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len = (k == 0) ? 1 : (k > WIN_MAX) ? WIN_MAX : k;
    held = 0;
    oldest = 0;
    sorted_vals.delete();
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom_range(7);
      1: return SAMPLE_W'({$urandom} | 32'hffff_ff00);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_window();
    send_sample('0);
    send_sample('1);
    send_sample(32'h8000_0000);
  endtask

  task automatic test_directed_extremes();
    set_window(0);
    send_sample('1);
    set_window(127);
    for (int i = 0; i < 66; i++) send_sample((i % 2) ? '1 : '0);
    set_window(3);
    send_sample(5); send_sample(5); send_sample(5); send_sample(1); send_sample(9);
    set_window(4);
    send_sample('1); send_sample('0); send_sample('1); send_sample('0);
    send_sample(32'h5555_5555); send_sample(32'haaaa_aaaa);
  endtask

  task automatic test_random_windows();
    int sizes[6] = '{1, 2, 5, 8, 17, 64};
    for (int p = 0; p < 12; p++) begin
      set_window(p < 6 ? sizes[p] : $urandom_range(1, 16));
      in_idle_pct = (p == 3) ? 0 : 32;
      out_idle_pct = (p == 3) ? 0 : 32;
      repeat (90) send_sample(rand_sample());
    end
    in_idle_pct = 32;
    out_idle_pct = 32;
  endtask

  task automatic test_backpressure();
    set_window(6);
    hold_off = 300;
    repeat (90) send_sample(rand_sample());
  endtask

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin
    window_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: median %h cost %h", $time, out_median, out_cost);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (e.median !== out_median) begin
          $display("%0t median expected %h actual %h", $time, e.median, out_median);
          errors++;
        end
        if (e.cost !== out_cost) begin
          $display("%0t cost expected %h actual %h", $time, e.cost, out_cost);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_window();
    test_directed_extremes();
    test_random_windows();
    test_backpressure();
    wait_drain();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
